// ===== hdl/fresnel_dielectric_reflectance_core_assert.svh =====
// assertion macros shared by the fresnel reflectance rtl
// needs clk and rst in the scope of the module that uses them
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_CORE_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdr assertion failed");
`define FDR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdr assertion failed");
`else
`define FDR_ASSERT_IMP(lbl, ante, cons)
`define FDR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/fdr_pkg.sv =====
// shared types and constants of the fresnel reflectance core
// no dependencies
package fdr_pkg;

  localparam int COS_FRAC_BITS_DEF = 15;
  localparam int ETA_W             = 16;
  localparam int ETA2_W            = 2 * ETA_W;
  localparam int RATIO_FRAC        = 24;
  localparam int OUT_W             = 17;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;
  localparam int REG_SEL_BIT       = 2;

  localparam logic [OUT_W-1:0] ONE_Q16     = 17'h10000;
  localparam logic [ETA_W-1:0] ETA_INC_RST = 16'd4096;
  localparam logic [ETA_W-1:0] ETA_TRN_RST = 16'd6144;

  typedef enum logic [0:0] {
    REG_ETA_INCIDENT    = 1'b0,
    REG_ETA_TRANSMITTED = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ETA_W-1:0] eta_incident;
    logic [ETA_W-1:0] eta_transmitted;
  } eta_cfg_t;

endpackage

// ===== hdl/fresnel_dielectric_reflectance_core.sv =====
// top level of the unpolarized dielectric fresnel reflectance core
// depends on fdr_pkg, fdr_cfg, fdr_div_pipe, fdr_sqrt_pipe and the assertion header
//
// usage
// - input channel: in_valid/in_ready with cos_incident, signed Q1.15 cosine;
//   zero or negative means the ray is leaving and the indices swap
// - output channel: out_valid/out_ready with reflectance (Q1.16, 65536 is one)
//   and total_internal
// - apb port: eta_incident at 0x0, eta_transmitted at 0x4, both Q4.12;
//   write only while the pipe is empty
// - one request per cycle sustained while out_ready does not stall the output
// - the pipe runs through the bit-per-stage dividers (2F and 25 stages) and
//   the bit-per-stage square root (F+1 stages)
// - a stall on out_ready freezes the whole pipe; in_ready is low exactly
//   while a result is held and not taken, so nothing is dropped or repeated
// - synchronous reset empties the pipe and loads indices 1.0 and 1.5
`include "fresnel_dielectric_reflectance_core_assert.svh"
module fresnel_dielectric_reflectance_core #(
  parameter int COS_FRAC_BITS = fdr_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fdr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fdr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fdr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COS_FRAC_BITS:0]    cos_incident,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fdr_pkg::OUT_W-1:0]        reflectance,
  output logic                             total_internal
);
  import fdr_pkg::*;

  localparam int F      = COS_FRAC_BITS;
  localparam int MAGW   = F + 1;
  localparam int MSQW   = 2 * F + 2;
  localparam int SQW    = 2 * F + 1;
  localparam int LOW_W  = 16;
  localparam int HIW    = SQW - LOW_W;
  localparam int PLW    = ETA2_W + LOW_W;
  localparam int PHW    = ETA2_W + HIW;
  localparam int PW     = ETA2_W + SQW;
  localparam int SIDE1  = 1 + MAGW + 2 * ETA_W;
  localparam int AW     = ETA_W + MAGW;
  localparam int NW2    = AW + RATIO_FRAC;
  localparam int DW2    = AW + 1;
  localparam int QW2    = RATIO_FRAC + 1;
  localparam int SQ2W   = 2 * QW2;
  localparam int SUMW   = SQ2W + 1;
  localparam int SH     = 2 * RATIO_FRAC + 1 - 16;
  localparam int RQW    = SUMW - SH;

  eta_cfg_t eta;
  logic     adv;

  fdr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eta     (eta)
  );

  // whole pipe moves unless the output register holds an untaken result
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 0: magnitude of the cosine and index swap
  logic            neg;
  logic            entering;
  logic [MAGW-1:0] raw_u;
  logic [MAGW-1:0] mag_in;
  logic            s0_valid;
  logic [MAGW-1:0] s0_mag;
  logic [ETA_W-1:0] s0_ei, s0_et;

  assign raw_u    = $unsigned(cos_incident);
  assign neg      = raw_u[F];
  assign mag_in   = neg ? (~raw_u + MAGW'(1)) : raw_u;
  assign entering = !neg && (raw_u != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mag <= mag_in;
      s0_ei  <= entering ? eta.eta_incident : eta.eta_transmitted;
      s0_et  <= entering ? eta.eta_transmitted : eta.eta_incident;
    end
  end

  // stage 1: squares of the indices and of the cosine
  logic              s1_valid;
  logic [ETA2_W-1:0] s1_ei2, s1_et2;
  logic [MSQW-1:0]   s1_msq;
  logic [MAGW-1:0]   s1_mag;
  logic [ETA_W-1:0]  s1_ei, s1_et;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ei2 <= ETA2_W'(s0_ei) * ETA2_W'(s0_ei);
      s1_et2 <= ETA2_W'(s0_et) * ETA2_W'(s0_et);
      s1_msq <= MSQW'(s0_mag) * MSQW'(s0_mag);
      s1_mag <= s0_mag;
      s1_ei  <= s0_ei;
      s1_et  <= s0_et;
    end
  end

  // stage 2: sin^2 of the incident angle and two partial products of ei^2 * sin^2
  logic [MSQW-1:0]   sin_diff;
  logic [SQW-1:0]    sini2;
  logic              s2_valid;
  logic [PLW-1:0]    s2_pl;
  logic [PHW-1:0]    s2_ph;
  logic [ETA2_W-1:0] s2_et2;
  logic [MAGW-1:0]   s2_mag;
  logic [ETA_W-1:0]  s2_ei, s2_et;

  assign sin_diff = (MSQW'(1) << (2 * F)) - s1_msq;
  assign sini2    = sin_diff[SQW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pl  <= PLW'(s1_ei2) * PLW'(sini2[LOW_W-1:0]);
      s2_ph  <= PHW'(s1_ei2) * PHW'(sini2[SQW-1:LOW_W]);
      s2_et2 <= s1_et2;
      s2_mag <= s1_mag;
      s2_ei  <= s1_ei;
      s2_et  <= s1_et;
    end
  end

  // stage 3: combine partial products
  logic              s3_valid;
  logic [PW-1:0]     s3_prod;
  logic [ETA2_W-1:0] s3_et2;
  logic [MAGW-1:0]   s3_mag;
  logic [ETA_W-1:0]  s3_ei, s3_et;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_prod <= PW'(s2_pl) + (PW'(s2_ph) << LOW_W);
      s3_et2  <= s2_et2;
      s3_mag  <= s2_mag;
      s3_ei   <= s2_ei;
      s3_et   <= s2_et;
    end
  end

  // stage 4: exact total internal reflection test
  logic              s4_valid;
  logic              s4_tir;
  logic [PW-1:0]     s4_prod;
  logic [ETA2_W-1:0] s4_et2;
  logic [MAGW-1:0]   s4_mag;
  logic [ETA_W-1:0]  s4_ei, s4_et;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tir  <= s3_prod >= (PW'(s3_et2) << (2 * F));
      s4_prod <= s3_prod;
      s4_et2  <= s3_et2;
      s4_mag  <= s3_mag;
      s4_ei   <= s3_ei;
      s4_et   <= s3_et;
    end
  end

  // sin^2 of the refracted angle
  logic             d1_valid;
  logic [2*F-1:0]   d1_sint2;
  logic [SIDE1-1:0] d1_side;

  fdr_div_pipe #(
    .NW (PW),
    .DW (ETA2_W),
    .QW (2 * F),
    .SW (SIDE1)
  ) u_div_sint (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s4_valid),
    .num       (s4_prod),
    .den       (s4_et2),
    .side_in   ({s4_tir, s4_mag, s4_ei, s4_et}),
    .out_valid (d1_valid),
    .quot      (d1_sint2),
    .side_out  (d1_side)
  );

  // cosine of the refracted angle
  logic [SQW-1:0]   cos2_t;
  logic             sq_valid;
  logic [MAGW-1:0]  sq_cost;
  logic [SIDE1-1:0] sq_side;
  logic             sq_tir;
  logic [MAGW-1:0]  sq_mag;
  logic [ETA_W-1:0] sq_ei, sq_et;

  assign cos2_t = (SQW'(1) << (2 * F)) - SQW'(d1_sint2);

  fdr_sqrt_pipe #(
    .XW (SQW),
    .RW (MAGW),
    .SW (SIDE1)
  ) u_sqrt_cost (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d1_valid),
    .x         (cos2_t),
    .side_in   (d1_side),
    .out_valid (sq_valid),
    .root      (sq_cost),
    .side_out  (sq_side)
  );

  assign {sq_tir, sq_mag, sq_ei, sq_et} = sq_side;

  // stage 5: the four products of the amplitude ratios
  logic          s5_valid;
  logic          s5_tir;
  logic [AW-1:0] s5_apar, s5_bpar, s5_aperp, s5_bperp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_tir   <= sq_tir;
      s5_apar  <= AW'(sq_et) * AW'(sq_mag);
      s5_bpar  <= AW'(sq_ei) * AW'(sq_cost);
      s5_aperp <= AW'(sq_ei) * AW'(sq_mag);
      s5_bperp <= AW'(sq_et) * AW'(sq_cost);
    end
  end

  // stage 6: difference magnitude and sum of each pair
  logic           s6_valid;
  logic           s6_tir;
  logic [AW-1:0]  s6_npar, s6_nperp;
  logic [DW2-1:0] s6_dpar, s6_dperp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_tir   <= s5_tir;
      s6_npar  <= (s5_apar >= s5_bpar) ? (s5_apar - s5_bpar) : (s5_bpar - s5_apar);
      s6_nperp <= (s5_aperp >= s5_bperp) ? (s5_aperp - s5_bperp) : (s5_bperp - s5_aperp);
      s6_dpar  <= DW2'(s5_apar) + DW2'(s5_bpar);
      s6_dperp <= DW2'(s5_aperp) + DW2'(s5_bperp);
    end
  end

  // both ratios in Q1.24; a zero sum counts as a ratio of one
  logic           d2_valid;
  logic [QW2-1:0] d2_qpar, d2_qperp;
  logic [1:0]     d2_side_par;
  logic           d2_dz_perp;
  logic           d2_perp_valid;

  fdr_div_pipe #(
    .NW (NW2),
    .DW (DW2),
    .QW (QW2),
    .SW (2)
  ) u_div_par (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s6_valid),
    .num       (NW2'(s6_npar) << RATIO_FRAC),
    .den       (s6_dpar),
    .side_in   ({s6_tir, s6_dpar == '0}),
    .out_valid (d2_valid),
    .quot      (d2_qpar),
    .side_out  (d2_side_par)
  );

  fdr_div_pipe #(
    .NW (NW2),
    .DW (DW2),
    .QW (QW2),
    .SW (1)
  ) u_div_perp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s6_valid),
    .num       (NW2'(s6_nperp) << RATIO_FRAC),
    .den       (s6_dperp),
    .side_in   (s6_dperp == '0),
    .out_valid (d2_perp_valid),
    .quot      (d2_qperp),
    .side_out  (d2_dz_perp)
  );

  // stage 7: squared ratios
  logic [QW2-1:0]  rpar, rperp;
  logic            s7_valid;
  logic            s7_tir;
  logic [SQ2W-1:0] s7_sq_par, s7_sq_perp;

  assign rpar  = d2_side_par[0] ? (QW2'(1) << RATIO_FRAC) : d2_qpar;
  assign rperp = d2_dz_perp ? (QW2'(1) << RATIO_FRAC) : d2_qperp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (adv) begin
      s7_valid <= d2_valid && d2_perp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_tir     <= d2_side_par[1];
      s7_sq_par  <= SQ2W'(rpar) * SQ2W'(rpar);
      s7_sq_perp <= SQ2W'(rperp) * SQ2W'(rperp);
    end
  end

  // stage 8: mean, round half up to Q1.16, saturate, one on tir; output register
  logic [SUMW-1:0]  rsum;
  logic [RQW-1:0]   rq;
  logic [OUT_W-1:0] rsat;

  assign rsum = SUMW'(s7_sq_par) + SUMW'(s7_sq_perp) + (SUMW'(1) << (SH - 1));
  assign rq   = rsum[SUMW-1:SH];
  assign rsat = (rq > RQW'(ONE_Q16)) ? ONE_Q16 : rq[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      reflectance    <= s7_tir ? ONE_Q16 : rsat;
      total_internal <= s7_tir;
    end
  end

  `FDR_ASSERT_IMP(a_tir_is_full, out_valid && total_internal, reflectance == ONE_Q16)
  `FDR_ASSERT_IMP(a_refl_range, out_valid, reflectance <= ONE_Q16)
  `FDR_ASSERT_NXT(a_stall_freezes_pipe, out_valid && !out_ready, $stable(s0_valid) && $stable(s7_valid) && $stable(s7_sq_par))
  `FDR_ASSERT_IMP(a_div_lanes_aligned, d2_valid || d2_perp_valid, d2_valid && d2_perp_valid)

endmodule

// ===== hdl/fdr_cfg.sv =====
// apb register file holding the two refractive indices
// depends on fdr_pkg
module fdr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fdr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fdr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fdr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output fdr_pkg::eta_cfg_t                eta
);
  import fdr_pkg::*;

  reg_idx_t sel;

  assign sel    = reg_idx_t'(paddr[REG_SEL_BIT]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta.eta_incident    <= ETA_INC_RST;
      eta.eta_transmitted <= ETA_TRN_RST;
    end else if (psel && penable && pwrite) begin
      case (sel)
        REG_ETA_INCIDENT:    eta.eta_incident    <= pwdata[ETA_W-1:0];
        REG_ETA_TRANSMITTED: eta.eta_transmitted <= pwdata[ETA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_ETA_INCIDENT:    prdata = APB_DATA_W'(eta.eta_incident);
      REG_ETA_TRANSMITTED: prdata = APB_DATA_W'(eta.eta_transmitted);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== hdl/fdr_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, side data carried along
// needs quotient below 2**QW; no package dependency
module fdr_div_pipe #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r   [QW];
  logic [DW-1:0] den_r   [QW];
  logic [QW-1:0] q_r     [QW];
  logic [SW-1:0] side_r  [QW];
  logic          valid_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] side_s;
    logic          valid_in;
    logic [CW-1:0] rem_ext;
    logic [CW-1:0] trial;
    logic          fits;

    if (i == 0) begin : g_first
      assign rem_in   = num;
      assign den_in   = den;
      assign q_in     = '0;
      assign side_s   = side_in;
      assign valid_in = in_valid;
    end else begin : g_next
      assign rem_in   = rem_r[i-1];
      assign den_in   = den_r[i-1];
      assign q_in     = q_r[i-1];
      assign side_s   = side_r[i-1];
      assign valid_in = valid_r[i-1];
    end

    assign rem_ext = CW'(rem_in);
    assign trial   = CW'(den_in) << (QW - 1 - i);
    assign fits    = rem_ext >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_r[i] <= 1'b0;
      end else if (adv) begin
        valid_r[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= fits ? NW'(rem_ext - trial) : rem_in;
        den_r[i]  <= den_in;
        q_r[i]    <= q_in | (fits ? (QW'(1) << (QW - 1 - i)) : QW'(0));
        side_r[i] <= side_s;
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign quot      = q_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

// ===== hdl/fdr_sqrt_pipe.sv =====
// pipelined floor square root, one result bit per stage, side data carried along
// needs x below 2**(2*RW); no package dependency
module fdr_sqrt_pipe #(
  parameter int XW = 31,
  parameter int RW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [XW-1:0] x,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [RW-1:0] root,
  output logic [SW-1:0] side_out
);
  localparam int CW = (XW > 2 * RW) ? XW : 2 * RW;

  logic [XW-1:0] rem_r   [RW];
  logic [RW-1:0] res_r   [RW];
  logic [SW-1:0] side_r  [RW];
  logic          valid_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [XW-1:0] rem_in;
    logic [RW-1:0] res_in;
    logic [SW-1:0] side_s;
    logic          valid_in;
    logic [CW-1:0] rem_ext;
    logic [CW-1:0] inc;
    logic          fits;

    if (i == 0) begin : g_first
      assign rem_in   = x;
      assign res_in   = '0;
      assign side_s   = side_in;
      assign valid_in = in_valid;
    end else begin : g_next
      assign rem_in   = rem_r[i-1];
      assign res_in   = res_r[i-1];
      assign side_s   = side_r[i-1];
      assign valid_in = valid_r[i-1];
    end

    // (res + 2^b)^2 - res^2
    assign rem_ext = CW'(rem_in);
    assign inc     = (CW'(res_in) << (RW - i)) + (CW'(1) << (2 * (RW - 1 - i)));
    assign fits    = rem_ext >= inc;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_r[i] <= 1'b0;
      end else if (adv) begin
        valid_r[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= fits ? XW'(rem_ext - inc) : rem_in;
        res_r[i]  <= res_in | (fits ? (RW'(1) << (RW - 1 - i)) : RW'(0));
        side_r[i] <= side_s;
      end
    end
  end

  assign out_valid = valid_r[RW-1];
  assign root      = res_r[RW-1];
  assign side_out  = side_r[RW-1];

endmodule
